>>> rtl/modexp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package modexp_pkg;

    localparam int MSG_WIDTH       = 63;
    localparam int RES_WIDTH       = 31;
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int CNT_WIDTH       = $clog2(MSG_WIDTH);

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MODULUS  = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EXPONENT = CFG_INDEX_WIDTH'(1);

endpackage

`default_nettype wire

>>> rtl/modular_exponentiation.sv
`timescale 1ns / 1ps
`default_nettype none

// Computes message^exponent mod modulus by right-to-left square-and-multiply, with modulus
// and exponent set through the configuration port. One shift-add-reduce unit does all the
// arithmetic, one bit per cycle: it first reduces the message by the modulus, then does
// each multiply and each square bit by bit, from the exponent's low bit up to its top set
// bit. The next item can be taken once the result has gone to the output register. A zero
// modulus gives 0, also with a zero exponent, and otherwise a zero exponent gives 1; both
// skip the arithmetic. Input is stalled while an item is in progress; a finished result
// waits in an output register, and a further result waits until that register has been
// read.
module modular_exponentiation #(
    parameter int MOD_WIDTH = 31,
    parameter int EXP_WIDTH = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [modexp_pkg::MSG_WIDTH-1:0]       message,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic [modexp_pkg::RES_WIDTH-1:0]            result,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [modexp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [modexp_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import modexp_pkg::*;

    localparam int IDX_WIDTH  = $clog2(MOD_WIDTH);
    localparam int STEP_WIDTH = MOD_WIDTH + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MUL,
        ST_SQR,
        ST_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [MOD_WIDTH-1:0]   modulus_reg;
    logic [EXP_WIDTH-1:0]   exponent_reg;
    logic [MSG_WIDTH-1:0]   msg_reg, msg_next;
    logic [EXP_WIDTH-1:0]   exp_reg, exp_next;
    logic [MOD_WIDTH-1:0]   acc_reg, acc_next;
    logic [MOD_WIDTH-1:0]   pw_reg, pw_next;
    logic [MOD_WIDTH-1:0]   r_reg, r_next;
    logic [CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic [RES_WIDTH-1:0]   result_reg, result_next;
    logic                   out_valid_reg, out_valid_next;

    logic [MOD_WIDTH-1:0]   addend;
    logic [STEP_WIDTH-1:0]  step_sum;
    logic [STEP_WIDTH-1:0]  step_m1;
    logic [STEP_WIDTH-1:0]  step_m2;
    logic [MOD_WIDTH-1:0]   step_out;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= MOD_WIDTH'(1);
            exponent_reg <= EXP_WIDTH'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_MODULUS)
            begin
                modulus_reg <= cfg_data[MOD_WIDTH-1:0];
            end
            else if (cfg_index == CFG_EXPONENT)
            begin
                exponent_reg <= cfg_data[EXP_WIDTH-1:0];
            end
        end
    end

    // The shared step: r = (2r + addend) mod m, with r below m and addend no greater than m.
    always_comb
    begin
        case (state_reg)
            ST_REDUCE: addend = MOD_WIDTH'(msg_reg[cnt_reg]);
            ST_MUL:    addend = acc_reg[cnt_reg[IDX_WIDTH-1:0]] ? pw_reg : '0;
            ST_SQR:    addend = pw_reg[cnt_reg[IDX_WIDTH-1:0]] ? pw_reg : '0;
            default:   addend = '0;
        endcase
        step_sum = STEP_WIDTH'({r_reg, 1'b0}) + STEP_WIDTH'(addend);
        step_m1  = STEP_WIDTH'(modulus_reg);
        step_m2  = STEP_WIDTH'({modulus_reg, 1'b0});
        if (step_sum >= step_m2)
        begin
            step_out = MOD_WIDTH'(step_sum - step_m2);
        end
        else if (step_sum >= step_m1)
        begin
            step_out = MOD_WIDTH'(step_sum - step_m1);
        end
        else
        begin
            step_out = MOD_WIDTH'(step_sum);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        msg_next       = msg_reg;
        exp_next       = exp_reg;
        acc_next       = acc_reg;
        pw_next        = pw_reg;
        r_next         = r_reg;
        cnt_next       = cnt_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    msg_next = message;
                    exp_next = exponent_reg;
                    r_next   = '0;
                    cnt_next = CNT_WIDTH'(MSG_WIDTH - 1);
                    if (modulus_reg == '0)
                    begin
                        acc_next   = '0;
                        state_next = ST_FINISH;
                    end
                    else if (exponent_reg == '0)
                    begin
                        acc_next   = MOD_WIDTH'(1);
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        acc_next   = MOD_WIDTH'(1);
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                r_next   = step_out;
                cnt_next = cnt_reg - CNT_WIDTH'(1);
                if (cnt_reg == '0)
                begin
                    pw_next    = step_out;
                    r_next     = '0;
                    cnt_next   = CNT_WIDTH'(MOD_WIDTH - 1);
                    state_next = exp_reg[0] ? ST_MUL : ST_SQR;
                end
            end
            ST_MUL:
            begin
                r_next   = step_out;
                cnt_next = cnt_reg - CNT_WIDTH'(1);
                if (cnt_reg == '0)
                begin
                    acc_next   = step_out;
                    r_next     = '0;
                    cnt_next   = CNT_WIDTH'(MOD_WIDTH - 1);
                    state_next = (exp_reg[EXP_WIDTH-1:1] == '0) ? ST_FINISH : ST_SQR;
                end
            end
            ST_SQR:
            begin
                r_next   = step_out;
                cnt_next = cnt_reg - CNT_WIDTH'(1);
                if (cnt_reg == '0)
                begin
                    pw_next    = step_out;
                    r_next     = '0;
                    cnt_next   = CNT_WIDTH'(MOD_WIDTH - 1);
                    exp_next   = exp_reg >> 1;
                    state_next = exp_reg[1] ? ST_MUL : ST_SQR;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    result_next    = RES_WIDTH'(acc_reg);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            msg_reg       <= '0;
            exp_reg       <= '0;
            acc_reg       <= '0;
            pw_reg        <= '0;
            r_reg         <= '0;
            cnt_reg       <= '0;
            result_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            msg_reg       <= msg_next;
            exp_reg       <= exp_next;
            acc_reg       <= acc_next;
            pw_reg        <= pw_next;
            r_reg         <= r_next;
            cnt_reg       <= cnt_next;
            result_reg    <= result_next;
        end
    end

    a_partial_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_SQR) |-> (r_reg < modulus_reg))
        else $error("partial remainder not below the modulus");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && modulus_reg != '0 && result >= RES_WIDTH'(modulus_reg))
        |-> (result == RES_WIDTH'(1)))
        else $error("result beat not reduced by the modulus");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again before the item finished");

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    import modexp_pkg::*;

    localparam int MOD_BITS = 31;
    localparam int EXP_BITS = 32;
    localparam int RANDOM_ITEMS = 290;
    localparam int HOLD_CYCLES = 4000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int REPORT_LIMIT = 10;

    localparam logic [MSG_WIDTH-1:0] MSG_MAX = '1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED_LOW = CFG_INDEX_WIDTH'(2);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED_TOP = '1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [MSG_WIDTH-1:0] message = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [RES_WIDTH-1:0] result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

    logic [MOD_BITS-1:0] model_modulus = MOD_BITS'(1);
    logic [EXP_BITS-1:0] model_exponent = EXP_BITS'(1);

    logic [MSG_WIDTH-1:0] message_queue[$];
    logic [RES_WIDTH-1:0] expected_powers[$];

    int items_sent = 0;
    int results_done = 0;
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    logic hold_request = 1'b0;
    logic hold_taken = 1'b0;
    logic in_fire = 1'b0;

    modular_exponentiation #(
        .MOD_WIDTH(MOD_BITS),
        .EXP_WIDTH(EXP_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .message(message),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic logic [RES_WIDTH-1:0] power_mod(input logic [MSG_WIDTH-1:0] msg);
        logic [63:0] m;
        logic [63:0] acc;
        logic [63:0] pw;
        logic [EXP_BITS-1:0] e;
        m = 64'(model_modulus);
        if (m == 64'd0)
        begin
            return '0;
        end
        acc = 64'd1;
        pw = 64'(msg) % m;
        e = model_exponent;
        while (e != '0)
        begin
            if (e[0])
            begin
                acc = (acc * pw) % m;
            end
            e = e >> 1;
            pw = (pw * pw) % m;
        end
        return acc[RES_WIDTH-1:0];
    endfunction

    // The driver offers one beat at a time and holds it until it is taken.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_fire)
        begin
            if (message_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                message <= message_queue.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_request && !hold_taken)
        begin
            hold_left = HOLD_CYCLES;
            hold_taken = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        logic [RES_WIDTH-1:0] want;
        in_fire <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            expected_powers.push_back(power_mod(message));
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_powers.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("%0t: result beat %0d with nothing expected", $realtime, result);
                end
            end
            else
            begin
                want = expected_powers.pop_front();
                results_done <= results_done + 1;
                if (result !== want)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("%0t: result expected %0d, got %0d", $realtime, want, result);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
            || !rst_n)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                  input logic [CFG_DATA_WIDTH-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_MODULUS: model_modulus = data[MOD_BITS-1:0];
            CFG_EXPONENT: model_exponent = data[EXP_BITS-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_key(input logic [CFG_DATA_WIDTH-1:0] mod_data,
                            input logic [CFG_DATA_WIDTH-1:0] exp_data);
        write_register(CFG_MODULUS, mod_data);
        write_register(CFG_EXPONENT, exp_data);
    endtask

    task automatic queue_message(input logic [MSG_WIDTH-1:0] m);
        message_queue.push_back(m);
        items_sent = items_sent + 1;
    endtask

    task automatic wait_drained;
        do
            @(negedge clk);
        while (results_done != items_sent);
    endtask

    function automatic logic [MSG_WIDTH-1:0] random_message();
        logic [63:0] full;
        logic [63:0] m;
        full = {$urandom, $urandom};
        m = 64'(model_modulus);
        case ($urandom_range(0, 5))
            1: return MSG_WIDTH'($urandom_range(0, 15));
            2: return (m == 64'd0) ? full[MSG_WIDTH-1:0] : MSG_WIDTH'(full % m);
            3: return MSG_MAX - MSG_WIDTH'($urandom_range(0, 15));
            4: return MSG_WIDTH'(m * 64'($urandom_range(0, 1000)) + 64'($urandom_range(0, 3)));
            default: return full[MSG_WIDTH-1:0];
        endcase
    endfunction

    function automatic logic [CFG_DATA_WIDTH-1:0] random_modulus();
        case ($urandom_range(0, 4))
            1: return CFG_DATA_WIDTH'($urandom_range(1, 255));
            2: return CFG_DATA_WIDTH'(32'h7FFF_FFFF);
            3: return CFG_DATA_WIDTH'(1);
            4: return CFG_DATA_WIDTH'($urandom_range(2, 65535));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_DATA_WIDTH-1:0] random_exponent();
        case ($urandom_range(0, 5))
            2: return CFG_DATA_WIDTH'($urandom_range(0, 15));
            3: return CFG_DATA_WIDTH'(65537);
            4: return '1;
            5: return CFG_DATA_WIDTH'($urandom_range(0, 1023));
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int random_sent;
        int batch;
        random_sent = 0;
        send_idle_pct = 6;
        recv_idle_pct = 51;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset key: modulus one, so everything reduces to zero.
        @(posedge clk);
        queue_message('0);
        queue_message(MSG_MAX);
        queue_message(MSG_WIDTH'(5));
        wait_drained();

        load_key(32'h7FFF_FFFF, 32'hFFFF_FFFF);
        @(posedge clk);
        queue_message('0);
        queue_message(MSG_WIDTH'(1));
        queue_message(MSG_MAX);
        queue_message(MSG_WIDTH'(32'h7FFF_FFFF));
        queue_message(MSG_WIDTH'(32'h7FFF_FFFE));
        queue_message(MSG_WIDTH'({(MSG_WIDTH+1)/2{2'b10}}));
        queue_message(MSG_WIDTH'({(MSG_WIDTH+1)/2{2'b01}}));
        wait_drained();

        // A zero exponent gives one even with a modulus of one.
        load_key(32'd1, 32'd0);
        @(posedge clk);
        queue_message(MSG_WIDTH'(12345));
        queue_message(MSG_MAX);
        wait_drained();

        // Writes to unused indexes must leave the key alone.
        write_register(CFG_UNUSED_LOW, $urandom);
        write_register(CFG_UNUSED_TOP, $urandom);
        @(posedge clk);
        queue_message(MSG_WIDTH'(99));
        wait_drained();

        // Only bit 31 set: the masked modulus is zero, which forces a zero result.
        load_key(32'h8000_0000, 32'd65537);
        @(posedge clk);
        queue_message(MSG_MAX);
        queue_message(MSG_WIDTH'(3));
        wait_drained();
        write_register(CFG_EXPONENT, '0);
        @(posedge clk);
        queue_message(MSG_WIDTH'(7));
        wait_drained();

        load_key(32'd2, 32'h8000_0000);
        @(posedge clk);
        queue_message(MSG_WIDTH'(3));
        queue_message(MSG_MAX - MSG_WIDTH'(1));
        wait_drained();

        load_key(32'd1000003, 32'd3);
        @(posedge clk);
        queue_message(MSG_WIDTH'(1000002));
        queue_message(MSG_WIDTH'(1000003));
        queue_message(MSG_WIDTH'(1000004));
        wait_drained();

        while (random_sent < RANDOM_ITEMS)
        begin
            if (random_sent < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 6;
                recv_idle_pct = 51;
            end
            else if (random_sent < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 51;
                recv_idle_pct = 6;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            load_key(random_modulus(), random_exponent());
            batch = $urandom_range(8, 16);
            if (batch > RANDOM_ITEMS - random_sent)
            begin
                batch = RANDOM_ITEMS - random_sent;
            end
            @(posedge clk);
            for (int i = 0; i < batch; i++)
            begin
                queue_message(random_message());
            end
            // Once, in the second half of the run, hold the result side off long enough for the block to back up.
            if (random_sent >= RANDOM_ITEMS / 2)
            begin
                hold_request = 1'b1;
            end
            random_sent = random_sent + batch;
            wait_drained();
        end

        repeat (20) @(negedge clk);
        if (mismatches == 0 && expected_powers.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
